// ===== hw/rtl/usrr_pkg.sv =====
// types, constants and descriptor tables for the usb standard request responder
// no dependencies; used by every module of the block but usrr_fifo
package usrr_pkg;

	// default queue depths for the top level
	localparam int CMD_DEPTH_DEF = 2;
	localparam int RES_DEPTH_DEF = 2;

	// request keys: {bmRequestType, bRequest}
	localparam logic [15:0] REQ_GET_STATUS_DEV  = 16'h8000;
	localparam logic [15:0] REQ_GET_STATUS_IF   = 16'h8100;
	localparam logic [15:0] REQ_GET_STATUS_EP   = 16'h8200;
	localparam logic [15:0] REQ_GET_DESC        = 16'h8006;
	localparam logic [15:0] REQ_GET_DESC_IF     = 16'h8106;
	localparam logic [15:0] REQ_GET_CONFIG      = 16'h8008;
	localparam logic [15:0] REQ_GET_INTERFACE   = 16'h810A;
	localparam logic [15:0] REQ_CLEAR_FEAT_DEV  = 16'h0001;
	localparam logic [15:0] REQ_SET_FEAT_DEV    = 16'h0003;
	localparam logic [15:0] REQ_SET_ADDRESS     = 16'h0005;
	localparam logic [15:0] REQ_SET_DESC        = 16'h0007;
	localparam logic [15:0] REQ_SET_CONFIG      = 16'h0009;
	localparam logic [15:0] REQ_SET_INTERFACE   = 16'h010B;
	localparam logic [15:0] REQ_SET_SEL         = 16'h0030;
	localparam logic [15:0] REQ_SET_ISOCH_DELAY = 16'h0031;
	localparam logic [15:0] REQ_SYNCH_FRAME     = 16'h020C;

	// descriptor types in the high byte of wValue
	localparam logic [7:0] DT_DEVICE = 8'h01;
	localparam logic [7:0] DT_CONFIG = 8'h02;
	localparam logic [7:0] DT_STRING = 8'h03;
	localparam logic [7:0] DT_BOS    = 8'h0F;

	// response sizes in bytes
	localparam logic [5:0] DEV_SIZE  = 6'd18;
	localparam logic [5:0] CFG_SIZE  = 6'd38;
	localparam logic [5:0] BOS_SIZE  = 6'd15;
	localparam logic [5:0] LANG_SIZE = 6'd4;
	localparam logic [5:0] ONE_SIZE  = 6'd1;
	localparam logic [5:0] STAT_SIZE = 6'd2;
	localparam logic [2:0] STR_COUNT = 3'd5;

	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_DEV,
		SRC_CFG,
		SRC_BOS,
		SRC_LANG,
		SRC_STR,
		SRC_ONE,
		SRC_ZERO
	} src_t;

	typedef enum logic [1:0] {
		ST_NORMAL = 2'd0,
		ST_SHORT  = 2'd1,
		ST_STALL  = 2'd2
	} status_t;

	// one classified request, front to back
	typedef struct packed {
		src_t        src;
		logic [2:0]  str_idx;
		logic [5:0]  count;
		status_t     status;
		logic [15:0] residual;
	} cmd_t;

	// one result, back to the result queue
	typedef struct packed {
		logic [7:0]  data;
		logic        valid;
		logic        last;
		status_t     status;
		logic [15:0] residual;
		logic [7:0]  done;
	} res_t;

	localparam logic [7:0] DEV_ROM [0:17] = '{
		8'h12, 8'h01, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h08,
		8'h01, 8'h33, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h01
	};

	localparam logic [7:0] CFG_ROM [0:37] = '{
		8'h09, 8'h02, 8'h26, 8'h00, 8'h01, 8'h01, 8'h04, 8'hA0, 8'h00,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h0A,
		8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h0A,
		8'h06, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] BOS_ROM [0:14] = '{
		8'h05, 8'h0F, 8'h0F, 8'h00, 8'h01,
		8'h0A, 8'h10, 8'h03, 8'h00, 8'h08, 8'h00, 8'h03, 8'h0A, 8'h20, 8'h00
	};

	// language id list: english (us)
	localparam logic [7:0] LANG_ROM [0:3] = '{8'h04, 8'h03, 8'h09, 8'h04};

	// string text, one byte per character
	localparam logic [7:0] STR1_TXT [0:7] = '{
		8'h43, 8'h4F, 8'h4D, 8'h50, 8'h33, 8'h33, 8'h30, 8'h31
	};
	localparam logic [7:0] STR2_TXT [0:11] = '{
		8'h44, 8'h75, 8'h6D, 8'h6D, 8'h79, 8'h20,
		8'h44, 8'h65, 8'h76, 8'h69, 8'h63, 8'h65
	};
	localparam logic [7:0] STR3_TXT [0:1] = '{8'h30, 8'h31};
	localparam logic [7:0] STR4_TXT [0:25] = '{
		8'h44, 8'h75, 8'h6D, 8'h6D, 8'h79, 8'h20, 8'h55, 8'h53, 8'h42,
		8'h20, 8'h64, 8'h65, 8'h76, 8'h69, 8'h63, 8'h65, 8'h20, 8'h66,
		8'h6F, 8'h72, 8'h20, 8'h70, 8'h72, 8'h61, 8'h63, 8'h73
	};

	// full string descriptor length, utf-16 text plus two header bytes
	function automatic logic [5:0] str_size(input logic [2:0] idx);
		logic [5:0] s;
		case (idx)
			3'd1:    s = 6'd18;
			3'd2:    s = 6'd26;
			3'd3:    s = 6'd6;
			3'd4:    s = 6'd54;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] str_char(input logic [2:0] idx, input logic [4:0] pos);
		logic [7:0] c;
		case (idx)
			3'd1:    c = STR1_TXT[pos[2:0]];
			3'd2:    c = STR2_TXT[pos[3:0]];
			3'd3:    c = STR3_TXT[pos[0]];
			3'd4:    c = STR4_TXT[pos];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// response byte k of a classified request
	function automatic logic [7:0] rsp_byte(input src_t src, input logic [2:0] idx,
			input logic [5:0] k);
		logic [7:0] b;
		logic [4:0] pos;
		pos = k[5:1] - 5'd1;
		case (src)
			SRC_DEV:  b = DEV_ROM[k[4:0]];
			SRC_CFG:  b = CFG_ROM[k];
			SRC_BOS:  b = BOS_ROM[k[3:0]];
			SRC_LANG: b = LANG_ROM[k[1:0]];
			SRC_ONE:  b = 8'h01;
			SRC_STR: begin
				if (k == 6'd0) begin
					b = {2'b00, str_size(idx)};
				end else if (k == 6'd1) begin
					b = 8'h03;
				end else if (k[0]) begin
					b = 8'h00;
				end else begin
					b = str_char(idx, pos);
				end
			end
			default:  b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/usb_standard_request_responder_core.sv =====
// top level of the usb standard request responder
// depends on usrr_pkg, usrr_front, usrr_fifo, usrr_back
//
// Answers USB standard control requests from fixed descriptor tables. A setup request is
// pushed and decoded at once into a command queue; the response sequencer loads a command
// while idle and then gives one result per byte (1 to 54 results, or a single status-only
// result when no byte is sent) into a result queue, at one result per cycle while that
// queue has room. The sequencer sets the sustained rate; further requests are taken while
// the command queue has room. Results are popped in order; status, residual and
// done_count repeat on every result of a request and last marks the final one.
module usb_standard_request_responder_core #(
	parameter int CMD_DEPTH = usrr_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH = usrr_pkg::RES_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] value_field,
	input  logic [15:0] index_field,
	input  logic [15:0] length_field,
	input  logic        has_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  data_byte,
	output logic        byte_valid,
	output logic        last,
	output logic [1:0]  status,
	output logic [15:0] residual,
	output logic [7:0]  done_count
);

	usrr_pkg::cmd_t front_cmd;
	usrr_pkg::cmd_t queued_cmd;
	usrr_pkg::res_t back_res;
	usrr_pkg::res_t out_res;
	logic           cmd_empty;
	logic           cmd_pop;
	logic           res_full;
	logic           res_push;

	// request decode
	usrr_front u_front (
		.request_type (request_type),
		.request_code (request_code),
		.value_field  (value_field),
		.index_field  (index_field),
		.length_field (length_field),
		.has_buffer   (has_buffer),
		.cmd          (front_cmd)
	);

	// queue between decoder and sequencer
	usrr_fifo #(
		.WIDTH ($bits(usrr_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (queued_cmd),
		.empty  (cmd_empty)
	);

	// response sequencer
	usrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (queued_cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// result queue toward the consumer
	usrr_fifo #(
		.WIDTH ($bits(usrr_pkg::res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (back_res),
		.full   (res_full),
		.pop    (pop),
		.dout   (out_res),
		.empty  (empty)
	);

	// result ports
	assign data_byte  = out_res.data;
	assign byte_valid = out_res.valid;
	assign last       = out_res.last;
	assign status     = out_res.status;
	assign residual   = out_res.residual;
	assign done_count = out_res.done;

endmodule

// ===== hw/rtl/usrr_fifo.sv =====
// small register queue with first-word fall-through read
// no package dependency; used for the request queue and the result queue
module usrr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/usrr_front.sv =====
// request decoder: turns one setup request into a response command
// depends on usrr_pkg
module usrr_front (
	input  logic [7:0]     request_type,
	input  logic [7:0]     request_code,
	input  logic [15:0]    value_field,
	input  logic [15:0]    index_field,
	input  logic [15:0]    length_field,
	input  logic           has_buffer,
	output usrr_pkg::cmd_t cmd
);

	logic [7:0] dtype;
	logic [7:0] didx;

	assign dtype = value_field[15:8];
	assign didx  = value_field[7:0];

	// cut a response of the given size to wLength
	function automatic usrr_pkg::cmd_t fit(input usrr_pkg::src_t src, input logic [2:0] idx,
			input logic [5:0] size, input logic [15:0] len);
		usrr_pkg::cmd_t c;
		logic [15:0]    size_w;
		size_w    = {10'd0, size};
		c.src     = src;
		c.str_idx = idx;
		c.count   = (len < size_w) ? len[5:0] : size;
		c.residual = (len > size_w) ? len - size_w : 16'd0;
		c.status  = (c.residual != 16'd0) ? usrr_pkg::ST_SHORT : usrr_pkg::ST_NORMAL;
		return c;
	endfunction

	// request decode
	always_comb begin
		cmd = '{src: usrr_pkg::SRC_NONE, str_idx: 3'd0, count: 6'd0,
			status: usrr_pkg::ST_NORMAL, residual: 16'd0};
		case ({request_type, request_code})
			usrr_pkg::REQ_GET_CONFIG: begin
				if (has_buffer && length_field != 16'd0) begin
					cmd = fit(usrr_pkg::SRC_ONE, 3'd0, usrr_pkg::ONE_SIZE, length_field);
				end
			end
			usrr_pkg::REQ_GET_INTERFACE: begin
				if (index_field != 16'd0) begin
					cmd.status = usrr_pkg::ST_STALL;
				end else if (has_buffer && length_field != 16'd0) begin
					cmd = fit(usrr_pkg::SRC_ZERO, 3'd0, usrr_pkg::ONE_SIZE, length_field);
				end
			end
			usrr_pkg::REQ_GET_STATUS_DEV, usrr_pkg::REQ_GET_STATUS_IF,
			usrr_pkg::REQ_GET_STATUS_EP: begin
				if (has_buffer && length_field > 16'd1) begin
					cmd = fit(usrr_pkg::SRC_ZERO, 3'd0, usrr_pkg::STAT_SIZE, length_field);
				end
			end
			usrr_pkg::REQ_GET_DESC_IF: begin
				if (has_buffer) begin
					cmd.status = usrr_pkg::ST_STALL;
				end
			end
			usrr_pkg::REQ_GET_DESC: begin
				if (has_buffer) begin
					case (dtype)
						usrr_pkg::DT_DEVICE: begin
							if (didx != 8'd0) begin
								cmd.status = usrr_pkg::ST_STALL;
							end else begin
								cmd = fit(usrr_pkg::SRC_DEV, 3'd0, usrr_pkg::DEV_SIZE,
									length_field);
							end
						end
						usrr_pkg::DT_CONFIG: begin
							if (didx != 8'd0) begin
								cmd.status = usrr_pkg::ST_STALL;
							end else begin
								cmd = fit(usrr_pkg::SRC_CFG, 3'd0, usrr_pkg::CFG_SIZE,
									length_field);
							end
						end
						usrr_pkg::DT_BOS: begin
							cmd = fit(usrr_pkg::SRC_BOS, 3'd0, usrr_pkg::BOS_SIZE, length_field);
						end
						usrr_pkg::DT_STRING: begin
							if (didx == 8'd0) begin
								// language list: full or at most the header, never short
								cmd.src = usrr_pkg::SRC_LANG;
								if (length_field >= {10'd0, usrr_pkg::LANG_SIZE}) begin
									cmd.count    = usrr_pkg::LANG_SIZE;
									cmd.residual = length_field - {10'd0, usrr_pkg::LANG_SIZE};
								end else begin
									cmd.count = (length_field < 16'd2) ? length_field[5:0]
										: 6'd2;
								end
							end else if (didx < {5'd0, usrr_pkg::STR_COUNT}) begin
								cmd = fit(usrr_pkg::SRC_STR, didx[2:0], usrr_pkg::str_size(didx[2:0]),
									length_field);
							end
						end
						default: begin
							cmd.status = usrr_pkg::ST_STALL;
						end
					endcase
				end
			end
			usrr_pkg::REQ_CLEAR_FEAT_DEV, usrr_pkg::REQ_SET_FEAT_DEV, usrr_pkg::REQ_SET_ADDRESS,
			usrr_pkg::REQ_SET_DESC, usrr_pkg::REQ_SET_CONFIG, usrr_pkg::REQ_SET_INTERFACE,
			usrr_pkg::REQ_SET_SEL, usrr_pkg::REQ_SET_ISOCH_DELAY, usrr_pkg::REQ_SYNCH_FRAME: begin
				// accepted and ignored
				cmd.status = usrr_pkg::ST_NORMAL;
			end
			default: begin
				cmd.status = usrr_pkg::ST_STALL;
			end
		endcase
	end

endmodule

// ===== hw/rtl/usrr_back.sv =====
// response sequencer: plays out one command as a run of result bytes
// depends on usrr_pkg
module usrr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  usrr_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           res_full,
	output logic           res_push,
	output usrr_pkg::res_t res
);

	logic           active_q;
	usrr_pkg::cmd_t cmd_q;
	logic [5:0]     k_q;
	logic           no_bytes;
	logic           last_emit;

	assign no_bytes  = (cmd_q.count == 6'd0);
	assign last_emit = no_bytes || (k_q == cmd_q.count - 6'd1);
	assign cmd_pop   = !active_q && !cmd_empty;
	assign res_push  = active_q && !res_full;

	// result fields for the current byte
	always_comb begin
		res.status = cmd_q.status;
		res.last   = last_emit;
		if (no_bytes) begin
			res.data     = 8'h00;
			res.valid    = 1'b0;
			res.residual = 16'd0;
			res.done     = 8'd0;
		end else begin
			res.data     = usrr_pkg::rsp_byte(cmd_q.src, cmd_q.str_idx, k_q);
			res.valid    = 1'b1;
			res.residual = cmd_q.residual;
			res.done     = {2'b00, cmd_q.count};
		end
	end

	// command hold
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	// byte counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= 6'd0;
		end else if (cmd_pop) begin
			active_q <= 1'b1;
			k_q      <= 6'd0;
		end else if (res_push) begin
			if (last_emit) begin
				active_q <= 1'b0;
			end else begin
				k_q <= k_q + 6'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/usrr_checker.sv =====
// port-level checks for the usb standard request responder
// depends on usrr_pkg; bound to usb_standard_request_responder_core
module usrr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  data_byte,
	input logic        byte_valid,
	input logic        last,
	input logic [1:0]  status,
	input logic [15:0] residual,
	input logic [7:0]  done_count
);

	// a waiting result is not withdrawn
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result vanished without pop");

	// a status-only result ends its request and reports no bytes
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !byte_valid |-> last && data_byte == 8'h00 && residual == 16'd0 &&
			done_count == 8'd0)
		else $error("status-only result malformed");

	// a stalled request never carries data
	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == usrr_pkg::ST_STALL |-> !byte_valid)
		else $error("stalled request carried data");

	// a data result always counts at least one byte
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && byte_valid |-> done_count != 8'd0)
		else $error("data result with zero byte count");

endmodule

bind usb_standard_request_responder_core usrr_checker u_usrr_checker (.*);

// ===== test/tb_usb_standard_request_responder_core.sv =====
// testbench for usb_standard_request_responder_core: setup requests in, response bytes out
// depends on usrr_pkg and the responder rtl; self-contained, predicts every response itself
`timescale 1ns / 1ps

module tb_usb_standard_request_responder_core;

	// run shape
	localparam int RANDOM_REQS   = 500;
	localparam int DRAIN_AT      = 80;
	localparam int CALM_FROM     = 150;
	localparam int CALM_TO       = 260;
	localparam int HOLD_AT       = 350;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 120;
	localparam int IDLE_PCT      = 24;

	// requests the block stalls on, not in the package
	localparam logic [15:0] REQ_CLEAR_FEAT_IF = 16'h0101;
	localparam logic [15:0] REQ_SET_FEAT_EP   = 16'h0203;
	localparam logic [7:0]  DT_INTERFACE      = 8'h04;

	localparam logic [15:0] KNOWN_REQS [0:17] = '{
		usrr_pkg::REQ_GET_STATUS_DEV, usrr_pkg::REQ_GET_STATUS_IF,
		usrr_pkg::REQ_GET_STATUS_EP, usrr_pkg::REQ_GET_DESC,
		usrr_pkg::REQ_GET_DESC_IF, usrr_pkg::REQ_GET_CONFIG,
		usrr_pkg::REQ_GET_INTERFACE, usrr_pkg::REQ_CLEAR_FEAT_DEV,
		usrr_pkg::REQ_SET_FEAT_DEV, usrr_pkg::REQ_SET_ADDRESS,
		usrr_pkg::REQ_SET_DESC, usrr_pkg::REQ_SET_CONFIG,
		usrr_pkg::REQ_SET_INTERFACE, usrr_pkg::REQ_SET_SEL,
		usrr_pkg::REQ_SET_ISOCH_DELAY, usrr_pkg::REQ_SYNCH_FRAME,
		REQ_CLEAR_FEAT_IF, REQ_SET_FEAT_EP
	};
	localparam logic [15:0] IGNORED_REQS [0:8] = '{
		usrr_pkg::REQ_SET_ADDRESS, usrr_pkg::REQ_SET_CONFIG, usrr_pkg::REQ_SET_DESC,
		usrr_pkg::REQ_CLEAR_FEAT_DEV, usrr_pkg::REQ_SET_FEAT_DEV,
		usrr_pkg::REQ_SET_INTERFACE, usrr_pkg::REQ_SET_ISOCH_DELAY,
		usrr_pkg::REQ_SET_SEL, usrr_pkg::REQ_SYNCH_FRAME
	};
	localparam logic [7:0] DESC_TYPES [0:5] = '{
		usrr_pkg::DT_DEVICE, usrr_pkg::DT_CONFIG, usrr_pkg::DT_STRING,
		usrr_pkg::DT_STRING, usrr_pkg::DT_BOS, DT_INTERFACE
	};

	// descriptor contents as the host should see them
	localparam logic [7:0] DEVICE_DESC [0:17] = '{
		8'h12, 8'h01, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h08,
		8'h01, 8'h33, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h01
	};
	localparam logic [7:0] CONFIG_SET [0:37] = '{
		8'h09, 8'h02, 8'h26, 8'h00, 8'h01, 8'h01, 8'h04, 8'hA0, 8'h00,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h0A,
		8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h0A,
		8'h06, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00
	};
	localparam logic [7:0] BOS_SET [0:14] = '{
		8'h05, 8'h0F, 8'h0F, 8'h00, 8'h01,
		8'h0A, 8'h10, 8'h03, 8'h00, 8'h08, 8'h00, 8'h03, 8'h0A, 8'h20, 8'h00
	};
	localparam logic [7:0] LANG_LIST [0:3] = '{8'h04, 8'h03, 8'h09, 8'h04};

	// string text, first character in the top byte
	localparam logic [63:0]  MFR_TXT     = 64'h434F_4D50_3333_3031;
	localparam logic [95:0]  PRODUCT_TXT = "Dummy Device";
	localparam logic [15:0]  SERIAL_TXT  = "01";
	localparam logic [207:0] IFACE_TXT   = "Dummy USB device for pracs";

	typedef struct packed {
		logic [7:0]  rtype;
		logic [7:0]  rcode;
		logic [15:0] wvalue;
		logic [15:0] windex;
		logic [15:0] wlength;
		logic        has_buf;
	} setup_req_t;

	typedef struct packed {
		logic [7:0]        data;
		logic              valid;
		logic              last;
		usrr_pkg::status_t status;
		logic [15:0]       residual;
		logic [7:0]        done;
	} resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  request_type = '0;
	logic [7:0]  request_code = '0;
	logic [15:0] value_field = '0;
	logic [15:0] index_field = '0;
	logic [15:0] length_field = '0;
	logic        has_buffer = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        last;
	logic [1:0]  status;
	logic [15:0] residual;
	logic [7:0]  done_count;

	setup_req_t pending_reqs[$];
	resp_t      awaited_resp[$];
	int         accepted_reqs = 0;
	int         mismatch_count = 0;
	logic       req_taken = 1'b0;
	bit         drained = 1'b0;
	bit         hold_done = 1'b0;
	int         hold_left = 0;

	usb_standard_request_responder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request_type(request_type),
		.request_code(request_code),
		.value_field(value_field),
		.index_field(index_field),
		.length_field(length_field),
		.has_buffer(has_buffer),
		.empty(empty),
		.pop(pop),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.last(last),
		.status(status),
		.residual(residual),
		.done_count(done_count)
	);

	always #5 clk = ~clk;

	// single reset pulse at the start
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int idle_pct();
		return (accepted_reqs >= CALM_FROM && accepted_reqs < CALM_TO) ? 0 : IDLE_PCT;
	endfunction

	function automatic int unsigned text_len(input int unsigned idx);
		int unsigned n;
		case (idx)
			1:       n = 8;
			2:       n = 12;
			3:       n = 2;
			default: n = 26;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] text_char(input int unsigned idx, input int unsigned pos);
		logic [7:0] c;
		case (idx)
			1:       c = MFR_TXT[8*(7-pos) +: 8];
			2:       c = PRODUCT_TXT[8*(11-pos) +: 8];
			3:       c = SERIAL_TXT[8*(1-pos) +: 8];
			default: c = IFACE_TXT[8*(25-pos) +: 8];
		endcase
		return c;
	endfunction

	// work out the response of one request and queue its results
	task automatic predict_response(input setup_req_t r);
		logic [7:0]        body [0:53];
		int unsigned       nbytes;
		int unsigned       dsize;
		int unsigned       n;
		int unsigned       k;
		usrr_pkg::status_t st;
		logic [15:0]       resid;
		logic [15:0]       key;
		logic [7:0]        dtype;
		logic [7:0]        didx;
		resp_t             e;
		nbytes = 0;
		dsize = 0;
		st = usrr_pkg::ST_NORMAL;
		resid = '0;
		key = {r.rtype, r.rcode};
		dtype = r.wvalue[15:8];
		didx = r.wvalue[7:0];
		case (key)
			usrr_pkg::REQ_GET_CONFIG: begin
				if (r.has_buf && r.wlength > 0) begin
					body[0] = 8'd1;
					dsize = 1;
				end
			end
			usrr_pkg::REQ_GET_INTERFACE: begin
				if (r.windex != 0) begin
					st = usrr_pkg::ST_STALL;
				end else if (r.has_buf && r.wlength > 0) begin
					body[0] = 8'd0;
					dsize = 1;
				end
			end
			usrr_pkg::REQ_GET_STATUS_DEV, usrr_pkg::REQ_GET_STATUS_IF,
			usrr_pkg::REQ_GET_STATUS_EP: begin
				if (r.has_buf && r.wlength > 1) begin
					body[0] = 8'd0;
					body[1] = 8'd0;
					dsize = 2;
				end
			end
			usrr_pkg::REQ_GET_DESC_IF: begin
				if (r.has_buf)
					st = usrr_pkg::ST_STALL;
			end
			usrr_pkg::REQ_GET_DESC: begin
				if (r.has_buf) begin
					case (dtype)
						usrr_pkg::DT_DEVICE: begin
							if (didx != 0) begin
								st = usrr_pkg::ST_STALL;
							end else begin
								for (k = 0; k < 18; k++)
									body[k] = DEVICE_DESC[k];
								dsize = 18;
							end
						end
						usrr_pkg::DT_CONFIG: begin
							if (didx != 0) begin
								st = usrr_pkg::ST_STALL;
							end else begin
								for (k = 0; k < 38; k++)
									body[k] = CONFIG_SET[k];
								dsize = 38;
							end
						end
						usrr_pkg::DT_BOS: begin
							for (k = 0; k < 15; k++)
								body[k] = BOS_SET[k];
							dsize = 15;
						end
						usrr_pkg::DT_STRING: begin
							// language list never reports a short transfer
							if (didx == 0) begin
								for (k = 0; k < 4; k++)
									body[k] = LANG_LIST[k];
								if (r.wlength >= 4) begin
									nbytes = 4;
									resid = r.wlength - 16'd4;
								end else begin
									nbytes = (r.wlength < 2) ? r.wlength : 2;
								end
							end else if (didx < 8'd5) begin
								n = text_len(didx);
								dsize = 2 + 2 * n;
								body[0] = dsize[7:0];
								body[1] = usrr_pkg::DT_STRING;
								for (k = 0; k < n; k++) begin
									body[2 + 2 * k] = text_char(didx, k);
									body[3 + 2 * k] = 8'h00;
								end
							end
						end
						default: st = usrr_pkg::ST_STALL;
					endcase
				end
			end
			usrr_pkg::REQ_SET_ADDRESS, usrr_pkg::REQ_SET_CONFIG, usrr_pkg::REQ_SET_DESC,
			usrr_pkg::REQ_CLEAR_FEAT_DEV, usrr_pkg::REQ_SET_FEAT_DEV,
			usrr_pkg::REQ_SET_INTERFACE, usrr_pkg::REQ_SET_ISOCH_DELAY,
			usrr_pkg::REQ_SET_SEL, usrr_pkg::REQ_SYNCH_FRAME: begin
			end
			default: st = usrr_pkg::ST_STALL;
		endcase

		// cut to wLength
		if (dsize > 0) begin
			nbytes = (r.wlength < dsize) ? r.wlength : dsize;
			resid = (r.wlength > dsize) ? r.wlength - dsize[15:0] : 16'd0;
			st = (resid != 0) ? usrr_pkg::ST_SHORT : usrr_pkg::ST_NORMAL;
		end

		if (nbytes == 0) begin
			e = '{data: 8'h00, valid: 1'b0, last: 1'b1, status: st, residual: 16'd0,
				done: 8'd0};
			awaited_resp.push_back(e);
		end else begin
			for (k = 0; k < nbytes; k++) begin
				e = '{data: body[k], valid: 1'b1, last: (k + 1 == nbytes), status: st,
					residual: resid, done: nbytes[7:0]};
				awaited_resp.push_back(e);
			end
		end
	endtask

	task automatic add_req(input logic [15:0] key, input logic [15:0] wvalue,
			input logic [15:0] windex, input logic [15:0] wlength, input logic has_buf);
		pending_reqs.push_back('{key[15:8], key[7:0], wvalue, windex, wlength, has_buf});
	endtask

	// mostly well-formed requests with random content, some pure noise
	function automatic setup_req_t random_req();
		setup_req_t  r;
		logic [15:0] key;
		logic [7:0]  dtype;
		logic [7:0]  didx;
		int          pick;
		int          lsel;
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.rtype = 8'($urandom_range(255));
			r.rcode = 8'($urandom_range(255));
			r.wvalue = 16'($urandom_range(65535));
			r.windex = 16'($urandom_range(65535));
			r.wlength = 16'($urandom_range(65535));
			r.has_buf = 1'($urandom_range(1));
		end else begin
			key = (pick < 55) ? usrr_pkg::REQ_GET_DESC : KNOWN_REQS[$urandom_range(17)];
			dtype = DESC_TYPES[$urandom_range(5)];
			if ($urandom_range(99) < 75)
				didx = (dtype == usrr_pkg::DT_STRING) ? 8'($urandom_range(5)) : 8'd0;
			else
				didx = 8'($urandom_range(255));
			lsel = $urandom_range(99);
			if (lsel < 55)
				r.wlength = 16'($urandom_range(64));
			else if (lsel < 80)
				r.wlength = 16'($urandom_range(4));
			else if (lsel < 90)
				r.wlength = 16'($urandom_range(255, 64));
			else
				r.wlength = 16'($urandom_range(65535));
			r.rtype = key[15:8];
			r.rcode = key[7:0];
			r.wvalue = {dtype, didx};
			r.windex = ($urandom_range(99) < 80) ? 16'd0 : 16'($urandom_range(65535));
			r.has_buf = ($urandom_range(99) < 88);
		end
		return r;
	endfunction

	// request driver, fed from the pending queue
	always @(negedge clk) begin : drive_requests
		bit offer;
		if (arst_n) begin
			if (req_taken)
				pending_reqs.delete(0);
			offer = pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct();
			// one pause until every response has come back
			if (accepted_reqs == DRAIN_AT && !drained) begin
				if (awaited_resp.size() == 0)
					drained = 1'b1;
				else
					offer = 1'b0;
			end
			if (offer) begin
				request_type <= pending_reqs[0].rtype;
				request_code <= pending_reqs[0].rcode;
				value_field <= pending_reqs[0].wvalue;
				index_field <= pending_reqs[0].windex;
				length_field <= pending_reqs[0].wlength;
				has_buffer <= pending_reqs[0].has_buf;
			end
			push <= offer;
		end
	end

	// result consumer with random stalls and one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && accepted_reqs >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= $urandom_range(99) >= idle_pct();
			end
		end
	end

	// monitor: predict on accepted requests, check popped results
	always @(posedge clk) begin : watch
		resp_t got;
		resp_t want;
		if (arst_n) begin
			if (push && !full) begin
				predict_response('{request_type, request_code, value_field, index_field,
					length_field, has_buffer});
				accepted_reqs <= accepted_reqs + 1;
			end
			if (pop && !empty) begin
				got = '{data_byte, byte_valid, last, usrr_pkg::status_t'(status), residual,
					done_count};
				if (awaited_resp.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with no request pending: data %02h valid %0b",
							$realtime, got.data, got.valid);
				end else begin
					want = awaited_resp.pop_front();
					if (got.data !== want.data || got.valid !== want.valid ||
							got.last !== want.last || got.status !== want.status ||
							got.residual !== want.residual || got.done !== want.done) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("%0t: expected data %02h valid %0b last %0b status %0d",
								$realtime, want.data, want.valid, want.last, want.status);
							$write(" residual %0d done %0d,", want.residual, want.done);
							$write(" got data %02h valid %0b last %0b status %0d",
								got.data, got.valid, got.last, got.status);
							$display(" residual %0d done %0d", got.residual, got.done);
						end
					end
				end
			end
		end
		req_taken <= arst_n && push && !full;
	end

	// stimulus and end of run
	initial begin : stimulus
		int i;
		// descriptors: short, exact length, stalled index and type, no buffer
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_DEVICE, 8'h00}, 16'h0000, 16'd64,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_DEVICE, 8'h01}, 16'h0000, 16'd64,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_CONFIG, 8'h00}, 16'hFFFF, 16'hFFFF,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_CONFIG, 8'hFF}, 16'h0000, 16'd9,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_BOS, 8'hFF}, 16'h0000, 16'd15, 1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {DT_INTERFACE, 8'h00}, 16'h0000, 16'd64, 1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_DEVICE, 8'h00}, 16'h0000, 16'd64,
			1'b0);
		// strings: language list full and cut, text strings, index past the table
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_STRING, 8'h00}, 16'h0409, 16'd255,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_STRING, 8'h00}, 16'h0409, 16'd1,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_STRING, 8'h01}, 16'h0409, 16'd255,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_STRING, 8'h04}, 16'h0409, 16'hFFFF,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_STRING, 8'h03}, 16'h0409, 16'd5,
			1'b1);
		add_req(usrr_pkg::REQ_GET_DESC, {usrr_pkg::DT_STRING, 8'h05}, 16'h0409, 16'd255,
			1'b1);
		// single-byte answers and status
		add_req(usrr_pkg::REQ_GET_DESC_IF, {usrr_pkg::DT_DEVICE, 8'h00}, 16'h0000, 16'd64,
			1'b1);
		add_req(usrr_pkg::REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'd1, 1'b1);
		add_req(usrr_pkg::REQ_GET_INTERFACE, 16'h0000, 16'h0003, 16'd1, 1'b0);
		add_req(usrr_pkg::REQ_GET_STATUS_DEV, 16'h0000, 16'h0000, 16'd1, 1'b1);
		add_req(usrr_pkg::REQ_GET_STATUS_EP, 16'hFFFF, 16'h0081, 16'hFFFF, 1'b1);
		// ignored set requests and one stalled feature request
		for (i = 0; i < 9; i++)
			add_req(IGNORED_REQS[i], 16'h0001, 16'h0000, 16'h0000, 1'b0);
		add_req(REQ_CLEAR_FEAT_IF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		for (i = 0; i < RANDOM_REQS; i++)
			pending_reqs.push_back(random_req());

		wait (arst_n === 1'b1);
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || push || awaited_resp.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
